[rtl/vsd_pkg.sv]
// Shared types and constants for the seven-segment digit generator.
// No dependencies; used by every module of the block.
package vsd_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W = 3;
    localparam int SEG_W = 8;

    localparam logic MODE_HEX = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               mode;
    } vsd_item_t;

    typedef struct packed {
        logic      valid;
        vsd_item_t item;
    } vsd_queue_out_t;

    function automatic logic [SEG_W-1:0] glyph(input logic [3:0] nib);
        logic [SEG_W-1:0] seg;
        case (nib)
            4'h0: seg = 8'h3F;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5B;
            4'h3: seg = 8'h4F;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6D;
            4'h6: seg = 8'h7D;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7F;
            4'h9: seg = 8'h6F;
            4'hA: seg = 8'h77;
            4'hB: seg = 8'h7C;
            4'hC: seg = 8'h39;
            4'hD: seg = 8'h5E;
            4'hE: seg = 8'h79;
            4'hF: seg = 8'h71;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

[rtl/vsd_front.sv]
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on vsd_pkg for the request type.
module vsd_front
    import vsd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [31:0]    value,
    input  logic           mode,
    output logic           full,
    output vsd_queue_out_t q_out,
    input  logic           q_take
);

    vsd_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign full = (count_reg == 2'd2);
    assign do_wr = push && !full;
    assign do_rd = q_take && (count_reg != 2'd0);

    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg].value <= value;
            mem_reg[wr_ptr_reg].mode <= (mode == MODE_DEC) ? MODE_DEC : MODE_HEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/vsd_back.sv]
// Back end: converts one request into digit glyphs, then emits them left to right.
// Depends on vsd_pkg for the request type, glyph table and reciprocal constant.
module vsd_back
    import vsd_pkg::*;
#(
    parameter int NUM_DIGITS = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  vsd_queue_out_t q_in,
    output logic           q_take,
    output logic           empty,
    input  logic           pop,
    output logic [2:0]     digit_position,
    output logic [7:0]     segments,
    output logic           last
);

    localparam int CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_DIGITS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]        rest_reg, rest_next;
    logic               mode_reg, mode_next;
    logic [7:0]         seg_reg [NUM_DIGITS];
    logic [7:0]         seg_next [NUM_DIGITS];
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_pos_reg, out_pos_next;
    logic [7:0]         out_seg_reg, out_seg_next;
    logic               out_last_reg, out_last_next;
    logic [63:0]        prod;
    logic [31:0]        quot;
    logic [31:0]        quot_x10;
    logic [3:0]         rem;
    logic [7:0]         conv_glyph;
    logic [31:0]        conv_rest;

    assign empty = !out_valid_reg;
    assign digit_position = out_pos_reg;
    assign segments = out_seg_reg;
    assign last = out_last_reg;
    assign q_take = (state_reg == ST_IDLE);

    assign prod = 64'(rest_reg) * 64'(RECIP_TEN);
    assign quot = 32'(prod >> RECIP_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem = 4'(rest_reg - quot_x10);

    always_comb
    begin
        if (mode_reg == MODE_HEX)
        begin
            conv_glyph = glyph(rest_reg[3:0] & NIBBLE_MASK);
            conv_rest = rest_reg >> 4;
        end
        else if (rest_reg == 32'd0 && cnt_reg != '0)
        begin
            conv_glyph = 8'h00;
            conv_rest = rest_reg;
        end
        else
        begin
            conv_glyph = glyph(rem);
            conv_rest = quot;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rest_next = rest_reg;
        mode_next = mode_reg;
        seg_next = seg_reg;
        out_valid_next = out_valid_reg;
        out_pos_next = out_pos_reg;
        out_seg_next = out_seg_reg;
        out_last_next = out_last_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    rest_next = q_in.item.value;
                    mode_next = q_in.item.mode;
                    cnt_next = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                for (int i = 0; i < NUM_DIGITS - 1; i++)
                begin
                    seg_next[i] = seg_reg[i + 1];
                end
                seg_next[NUM_DIGITS - 1] = conv_glyph;
                rest_next = conv_rest;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next = 3'(cnt_reg);
                    out_seg_next = seg_reg[NUM_DIGITS - 1];
                    out_last_next = (cnt_reg == CNT_LAST);
                    for (int i = NUM_DIGITS - 1; i > 0; i--)
                    begin
                        seg_next[i] = seg_reg[i - 1];
                    end
                    seg_next[0] = 8'h00;
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        mode_reg <= mode_next;
        seg_reg <= seg_next;
        out_pos_reg <= out_pos_next;
        out_seg_reg <= out_seg_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/value_to_seven_segment_digits_top.sv]
// Top level of the seven-segment digit generator.
// Depends on vsd_pkg, vsd_front and vsd_back.
//
// Each request carries a 32-bit value and a mode (hexadecimal or decimal) and
// produces NUM_DIGITS results, leftmost digit first, with last set on the
// rightmost one. A two-entry request queue sits at the input, so new requests
// are taken while the converter works. The converter takes a request, forms
// its digits (one reciprocal multiply by a tenth, or one nibble, per cycle),
// then emits them as results are popped, and takes no further request until
// the last digit of the current one has been emitted.
module value_to_seven_segment_digits_top
    import vsd_pkg::*;
#(
    parameter int NUM_DIGITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] value,
    input  logic        mode,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  digit_position,
    output logic [7:0]  segments,
    output logic        last
);

    vsd_queue_out_t q_out;
    logic           q_take;

    vsd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .value  (value),
        .mode   (mode),
        .full   (full),
        .q_out  (q_out),
        .q_take (q_take)
    );

    vsd_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_in           (q_out),
        .q_take         (q_take),
        .empty          (empty),
        .pop            (pop),
        .digit_position (digit_position),
        .segments       (segments),
        .last           (last)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (digit_position == 3'(NUM_DIGITS - 1)))
        else $error("last flag on a digit other than the rightmost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=>
            (!empty && digit_position == $past(digit_position) + 3'd1))
        else $error("digit run broken or out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !segments[7])
        else $error("decimal point lit");

endmodule
